/* src/fcc_pkg.sv */
// Package for the frame checker and command classifier.
// Holds the item structs, the code register set, status and class codes and frame constants.
// No dependencies.
package fcc_pkg;

  // Input item: one received byte and its end-of-packet flag.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  // Result item, given once per packet on its final byte.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  cmd_class;
    logic [31:0] master_addr;
    logic [31:0] client_addr;
    logic [7:0]  first_data;
    logic [7:0]  computed_sum;
  } out_item_t;

  // The four configured command codes, without their bit 7.
  typedef struct packed {
    logic [6:0] read_id;
    logic [6:0] control;
    logic [6:0] read_ack;
    logic [6:0] config_order;
  } codes_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_READ_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CONTROL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_READ_ACK     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CONFIG_ORDER = 2'd3;

  localparam logic [6:0] RST_CODE_READ_ID      = 7'd0;
  localparam logic [6:0] RST_CODE_CONTROL      = 7'd1;
  localparam logic [6:0] RST_CODE_READ_ACK     = 7'd2;
  localparam logic [6:0] RST_CODE_CONFIG_ORDER = 7'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_HDR  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  localparam logic [2:0] CLS_READ_ID      = 3'd0;
  localparam logic [2:0] CLS_CONTROL      = 3'd1;
  localparam logic [2:0] CLS_READ_ACK     = 3'd2;
  localparam logic [2:0] CLS_CONFIG_ORDER = 3'd3;
  localparam logic [2:0] CLS_UNSUPPORTED  = 3'd4;

  localparam logic [7:0] SYNC_BYTE0   = 8'hAA;
  localparam logic [7:0] SYNC_BYTE1   = 8'h55;
  localparam logic [7:0] CODE_MARK    = 8'h80;

  // Byte positions within a packet.
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] POS_SYNC0      = 6'd0;
  localparam logic [CNT_W-1:0] POS_SYNC1      = 6'd1;
  localparam logic [CNT_W-1:0] POS_LENGTH     = 6'd2;
  localparam logic [CNT_W-1:0] POS_MASTER_LO  = 6'd3;
  localparam logic [CNT_W-1:0] POS_MASTER_HI  = 6'd6;
  localparam logic [CNT_W-1:0] POS_CLIENT_LO  = 6'd7;
  localparam logic [CNT_W-1:0] POS_CLIENT_HI  = 6'd10;
  localparam logic [CNT_W-1:0] POS_TYPE       = 6'd11;
  localparam logic [CNT_W-1:0] POS_DATA       = 6'd12;
  localparam logic [CNT_W-1:0] CNT_SATURATE   = 6'd63;

  // The summed window runs from the length byte to index L plus this offset.
  localparam logic [8:0] SUM_WINDOW_EXTRA = 9'd10;

endpackage

/* src/fcc_classify.sv */
// Command classifier: matches a type byte against the four configured codes.
// Depends on fcc_pkg.
module fcc_classify (
  input  logic [7:0]     type_byte,
  input  fcc_pkg::codes_t codes,
  output logic [2:0]     cmd_class
);
  import fcc_pkg::*;

  // Each code is compared with bit 7 set; the first match wins.
  always_comb begin
    if (type_byte == ({1'b0, codes.read_id} | CODE_MARK)) begin
      cmd_class = CLS_READ_ID;
    end else if (type_byte == ({1'b0, codes.control} | CODE_MARK)) begin
      cmd_class = CLS_CONTROL;
    end else if (type_byte == ({1'b0, codes.read_ack} | CODE_MARK)) begin
      cmd_class = CLS_READ_ACK;
    end else if (type_byte == ({1'b0, codes.config_order} | CODE_MARK)) begin
      cmd_class = CLS_CONFIG_ORDER;
    end else begin
      cmd_class = CLS_UNSUPPORTED;
    end
  end

endmodule

/* src/frame_checker_command_classifier.sv */
// Top level of the frame checker and command classifier.
// Depends on fcc_pkg and fcc_classify.
//
// Usage. Received packet bytes enter on the input channel (in_valid, in_stall, in_data), one
// item per byte in arrival order, with last_byte set on the final byte. Every packet must have
// at least twelve bytes and begin with the sync pair 0xAA 0x55; byte 2 is a length L, and the
// bytes from index 2 to L+10 are summed modulo 256 and compared with the final byte. Bytes at
// an index of MAX_PACKET or more are dropped and the packet is reported as too long.
// For each packet exactly one result item leaves on the output channel (out_valid, out_stall,
// out_data): the status, the command class, the master and client identifiers, the first data
// byte and the computed sum. A rejected packet always reports the unsupported class.
// Throughput is one byte per cycle but for the stall below: the counter, the running sum and
// the captured fields are updated together; the result, formed from them combinationally,
// is held in the output register and appears in the cycle after its final byte is accepted.
// When the receiver stalls and the output register is full, only a final byte is held back;
// other bytes keep flowing because they produce no result.
// The user must write the command codes (cfg_we, cfg_index, cfg_data) only while the block
// is idle; the block does not enforce this. Reset (rst, synchronous, active high) clears the
// packet state, empties the output register and returns the command codes to 0, 1, 2 and 3.
module frame_checker_command_classifier #(
  parameter int MAX_PACKET = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fcc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fcc_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fcc_pkg::*;

  localparam logic [CNT_W-1:0] MAX_POS = CNT_W'(MAX_PACKET);

  // Configuration registers.
  codes_t codes;

  // Packet state.
  logic [CNT_W-1:0] byte_count;
  logic             header_good;
  logic [7:0]       length_field;
  logic [7:0]       running_sum;
  logic [31:0]      master_reg;
  logic [31:0]      client_reg;
  logic [7:0]       type_reg;
  logic [7:0]       data_reg;
  logic             overflow_flag;

  logic             header_good_next;
  logic [7:0]       length_field_next;
  logic [7:0]       running_sum_next;
  logic [31:0]      master_reg_next;
  logic [31:0]      client_reg_next;
  logic [7:0]       type_reg_next;
  logic [7:0]       data_reg_next;
  logic             overflow_flag_next;
  logic [CNT_W-1:0] byte_count_next;

  logic             in_fire;
  logic             in_window;
  logic             in_sum;
  logic [1:0]       status_next;
  logic [2:0]       class_match;
  out_item_t        result_next;
  logic [7:0]       b;

  assign b = in_data.rx_byte;

  // Only a final byte needs room in the output register.
  assign in_stall = out_valid & out_stall & in_data.last_byte;
  assign in_fire  = in_valid & ~in_stall;

  // Index within the stored part of the packet.
  assign in_window = (byte_count < MAX_POS);

  // The sum test uses the freshly captured length, so the length byte itself is always summed.
  assign in_sum = in_window && (byte_count >= POS_LENGTH) &&
                  ({3'b000, byte_count} <= ({1'b0, length_field_next} + SUM_WINDOW_EXTRA));

  always_comb begin
    header_good_next   = header_good;
    length_field_next  = length_field;
    master_reg_next    = master_reg;
    client_reg_next    = client_reg;
    type_reg_next      = type_reg;
    data_reg_next      = data_reg;
    overflow_flag_next = overflow_flag | ~in_window;
    if (in_window) begin
      case (byte_count) inside
        POS_SYNC0: begin
          if (b != SYNC_BYTE0) header_good_next = 1'b0;
        end
        POS_SYNC1: begin
          if (b != SYNC_BYTE1) header_good_next = 1'b0;
        end
        POS_LENGTH: begin
          length_field_next = b;
        end
        [POS_MASTER_LO:POS_MASTER_HI]: begin
          master_reg_next = {master_reg[23:0], b};
        end
        [POS_CLIENT_LO:POS_CLIENT_HI]: begin
          client_reg_next = {client_reg[23:0], b};
        end
        POS_TYPE: begin
          type_reg_next = b;
        end
        POS_DATA: begin
          data_reg_next = b;
        end
        default: begin
        end
      endcase
    end
  end

  assign running_sum_next = in_sum ? (running_sum + b) : running_sum;
  assign byte_count_next  = (byte_count == CNT_SATURATE) ? byte_count
                                                         : (byte_count + CNT_W'(1));

  fcc_classify u_classify (
    .type_byte (type_reg_next),
    .codes     (codes),
    .cmd_class (class_match)
  );

  // Status priority: too long, then short or bad header, then checksum.
  always_comb begin
    if (overflow_flag_next) begin
      status_next = ST_TOO_LONG;
    end else if ((byte_count < POS_TYPE) || !header_good_next) begin
      status_next = ST_BAD_HDR;
    end else if (running_sum_next != b) begin
      status_next = ST_CHECKSUM;
    end else begin
      status_next = ST_OK;
    end
  end

  always_comb begin
    result_next.status       = status_next;
    result_next.cmd_class    = (status_next == ST_OK) ? class_match : CLS_UNSUPPORTED;
    result_next.master_addr  = master_reg_next;
    result_next.client_addr  = client_reg_next;
    result_next.first_data   = data_reg_next;
    result_next.computed_sum = running_sum_next;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.read_id      <= RST_CODE_READ_ID;
      codes.control      <= RST_CODE_CONTROL;
      codes.read_ack     <= RST_CODE_READ_ACK;
      codes.config_order <= RST_CODE_CONFIG_ORDER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_READ_ID:      codes.read_id      <= cfg_data;
        REG_CODE_CONTROL:      codes.control      <= cfg_data;
        REG_CODE_READ_ACK:     codes.read_ack     <= cfg_data;
        REG_CODE_CONFIG_ORDER: codes.config_order <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Packet state: advanced on every accepted byte, cleared after the final one.
  always_ff @(posedge clk) begin
    if (rst || (in_fire && in_data.last_byte)) begin
      byte_count    <= '0;
      header_good   <= 1'b1;
      length_field  <= '0;
      running_sum   <= '0;
      master_reg    <= '0;
      client_reg    <= '0;
      type_reg      <= '0;
      data_reg      <= '0;
      overflow_flag <= 1'b0;
    end else if (in_fire) begin
      byte_count    <= byte_count_next;
      header_good   <= header_good_next;
      length_field  <= length_field_next;
      running_sum   <= running_sum_next;
      master_reg    <= master_reg_next;
      client_reg    <= client_reg_next;
      type_reg      <= type_reg_next;
      data_reg      <= data_reg_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_byte) begin
      out_data <= result_next;
    end
  end

  // A rejected packet never reports a supported class.
  a_reject_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.cmd_class == CLS_UNSUPPORTED))
    else $error("rejected packet reported with a supported class");

  // The final byte always clears the packet state.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.last_byte) |=> (byte_count == '0 && !overflow_flag && header_good))
    else $error("packet state not cleared after final byte");

  // The counter advances by one on each non-final byte until it saturates.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.last_byte && byte_count != CNT_SATURATE)
      |=> (byte_count == $past(byte_count) + CNT_W'(1)))
    else $error("byte counter did not advance");

  // Overflow is only flagged once the count has reached the maximum size.
  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (byte_count >= MAX_POS))
    else $error("overflow flagged inside the packet limit");

endmodule
